// ----- sv/weg_pkg.sv -----
`default_nettype none

package weg_pkg;

    localparam int MAX_FAN_IN    = 4096;
    localparam int FRAC_BITS_DEF = 16;

    localparam int DATA_W   = 32;
    localparam int ALPHA_W  = 31;
    localparam int W0_W     = 31;
    localparam int FAN_W    = 13;
    localparam int SUM_W    = 48;
    localparam int CFG_DW   = 31;

    // divider: divisor and remainder width, quotient width, iteration counter width
    localparam int DW       = 63;
    localparam int QW       = 41;
    localparam int CW       = 6;
    localparam int R_ITERS  = 33;

    localparam logic [QW-1:0] TERM_CAP = {1'b1, {(QW-1){1'b0}}};

    typedef enum logic [1:0] {
        CFG_ENABLE   = 2'd0,
        CFG_ALPHA    = 2'd1,
        CFG_SCALE_W0 = 2'd2,
        CFG_FAN_IN   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic          load;
        logic [DW-1:0] rem_init;
        logic [QW-1:0] nb_init;
        logic [CW-1:0] iters;
    } div_ctrl_t;

    typedef struct packed {
        logic          busy;
        logic [QW-1:0] quot;
    } div_stat_t;

endpackage

`default_nettype wire

// ----- sv/weg_in_if.sv -----
`default_nettype none

interface weg_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [weg_pkg::DATA_W-1:0]   weight;
    logic signed [weg_pkg::DATA_W-1:0]   gradient_in;
    logic                                last_weight;

    modport source (output valid, output weight, output gradient_in, output last_weight,
                    input ready);
    modport sink   (input valid, input weight, input gradient_in, input last_weight,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/weg_out_if.sv -----
`default_nettype none

interface weg_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [weg_pkg::DATA_W-1:0]   gradient_out;
    logic                                is_bias;
    logic        [weg_pkg::SUM_W-1:0]    penalty_sum;
    logic                                last_out;

    modport source (output valid, output gradient_out, output is_bias, output penalty_sum,
                    output last_out, input ready);
    modport sink   (input valid, input gradient_out, input is_bias, input penalty_sum,
                    input last_out, output ready);
endinterface

`default_nettype wire

// ----- sv/weg_divider.sv -----
`default_nettype none

module weg_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  weg_pkg::div_ctrl_t         ctrl,
    input  logic [weg_pkg::DW-1:0]     divisor,
    output weg_pkg::div_stat_t         stat
);
    import weg_pkg::*;

    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [QW-1:0] nb_reg;
    logic [QW-1:0] quot_reg;
    logic [DW:0]   rem_shift;
    logic [DW:0]   rem_diff;
    logic          rem_ge;

    assign rem_shift = {rem_reg, nb_reg[QW-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor};
    assign rem_ge    = rem_shift >= {1'b0, divisor};
    assign rem_next  = rem_ge ? rem_diff[DW-1:0] : rem_shift[DW-1:0];

    assign stat.busy = cnt_reg != '0;
    assign stat.quot = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.load)
        begin
            cnt_reg <= ctrl.iters;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    // one quotient bit per cycle, numerator bits enter MSB first
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg  <= ctrl.rem_init;
            nb_reg   <= ctrl.nb_init;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= rem_next;
            nb_reg   <= {nb_reg[QW-2:0], 1'b0};
            quot_reg <= {quot_reg[QW-2:0], rem_ge};
        end
    end

endmodule

`default_nettype wire

// ----- sv/weight_elimination_gradient_unit.sv -----
`default_nettype none
// A beat passes S_SQR and S_ADD, then up to three divides before S_FIN: none when weight
// and w0 are both zero, only the penalty divide when no gradient term applies, no quotient
// divide when the term is capped before it, all three otherwise. Data are Q16.16 by default.
// One radix-2 divider serves all three divisions. One item is in work at a time; a new beat
// is taken while a result waits, and the next result holds until the waiting one is taken.
// rst_n clears enable, alpha and scale_w0 to 0, fan_in to 1, row position and sum to zero.

module weight_elimination_gradient_unit #(
    parameter int FRAC_BITS = weg_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  weg_pkg::cfg_index_t           cfg_index,
    input  logic [weg_pkg::CFG_DW-1:0]    cfg_data,
    weg_in_if.sink                        sample,
    weg_out_if.source                     result
);
    import weg_pkg::*;

    localparam int PW  = 96;
    localparam int PSH = 32 - FRAC_BITS;
    localparam int TW  = PW - PSH - QW;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_SQR     = 9'b000000010,
        S_ADD     = 9'b000000100,
        S_PEN_GO  = 9'b000001000,
        S_PEN_RUN = 9'b000010000,
        S_R_RUN   = 9'b000100000,
        S_QCHK    = 9'b001000000,
        S_Q_RUN   = 9'b010000000,
        S_FIN     = 9'b100000000
    } state_t;

    state_t              state_reg;
    state_t              state_next;

    logic                enable_reg;
    logic [ALPHA_W-1:0]  alpha_reg;
    logic [W0_W-1:0]     w0_reg;
    logic [FAN_W-1:0]    fan_in_reg;
    logic [FAN_W-1:0]    pos_reg;
    logic [SUM_W-1:0]    acc_reg;
    logic                out_valid_reg;

    logic [DATA_W-1:0]   wmag_reg;
    logic                neg_reg;
    logic [DATA_W-1:0]   grad_reg;
    logic                last_reg;
    logic                bias_reg;
    logic                term_on_reg;
    logic [62:0]         w2_reg;
    logic [61:0]         v2_reg;
    logic [62:0]         m_reg;
    logic [DW-1:0]       s_reg;
    logic [PW-1:0]       p_reg;
    logic [PW-1:0]       p_next;
    logic [FRAC_BITS:0]  pen_reg;
    logic [QW-1:0]       mag_reg;

    logic [DATA_W-1:0]   grad_out_reg;
    logic                is_bias_reg;
    logic [SUM_W-1:0]    sum_out_reg;
    logic                last_out_reg;

    logic                in_fire;
    logic                fin_go;
    logic                bias_now;
    logic [DATA_W-1:0]   w_in;
    logic [DATA_W-1:0]   w_abs;
    logic [62:0]         w2_full;
    logic [61:0]         v2_full;
    logic [62:0]         m_full;
    logic [TW-1:0]       p_top;
    logic                p_ovf;
    logic signed [41:0]  mag_s;
    logic signed [41:0]  gsum;
    logic [DATA_W-1:0]   gsat;
    logic [SUM_W:0]      acc_sum;
    logic [SUM_W-1:0]    acc_next;

    div_ctrl_t           div_ctrl;
    div_stat_t           div_stat;

    weg_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (div_ctrl),
        .divisor (s_reg),
        .stat    (div_stat)
    );

    assign sample.ready = state_reg == S_IDLE;
    assign in_fire      = sample.valid && sample.ready;
    assign fin_go       = (state_reg == S_FIN) && (!out_valid_reg || result.ready);

    assign w_in     = sample.weight;
    assign w_abs    = w_in[DATA_W-1] ? (~w_in + DATA_W'(1)) : w_in;
    assign bias_now = (32'(pos_reg) >= 32'(fan_in_reg)) || (32'(pos_reg) >= 32'(MAX_FAN_IN));

    assign w2_full = 63'(wmag_reg) * 63'(wmag_reg);
    assign v2_full = 62'(w0_reg) * 62'(w0_reg);
    assign m_full  = 63'({alpha_reg, 1'b0}) * 63'(wmag_reg);

    assign p_next = (p_reg << 1) + (div_stat.quot[0] ? PW'(m_reg) : '0);
    assign p_top  = p_reg[PW-1:PSH+QW];
    assign p_ovf  = DW'(p_top) >= s_reg;

    assign mag_s   = $signed({1'b0, mag_reg});
    assign gsum    = $signed({{10{grad_reg[DATA_W-1]}}, grad_reg}) + (neg_reg ? -mag_s : mag_s);
    assign acc_sum = {1'b0, acc_reg} + (SUM_W+1)'(pen_reg);
    assign acc_next = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];

    always_comb
    begin
        if (gsum > 42'sd2147483647)
        begin
            gsat = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if (gsum < -42'sd2147483648)
        begin
            gsat = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            gsat = gsum[DATA_W-1:0];
        end
    end

    always_comb
    begin
        div_ctrl = '0;
        case (state_reg)
            S_PEN_GO:
            begin
                if (s_reg != '0)
                begin
                    div_ctrl.load     = 1'b1;
                    div_ctrl.rem_init = w2_reg >> 1;
                    div_ctrl.nb_init  = {w2_reg[0], {(QW-1){1'b0}}};
                    div_ctrl.iters    = CW'(FRAC_BITS + 1);
                end
            end
            S_PEN_RUN:
            begin
                if (!div_stat.busy && term_on_reg)
                begin
                    div_ctrl.load     = 1'b1;
                    div_ctrl.rem_init = DW'(v2_reg >> 1);
                    div_ctrl.nb_init  = {v2_reg[0], {(QW-1){1'b0}}};
                    div_ctrl.iters    = CW'(R_ITERS);
                end
            end
            S_QCHK:
            begin
                if (!p_ovf)
                begin
                    div_ctrl.load     = 1'b1;
                    div_ctrl.rem_init = DW'(p_top);
                    div_ctrl.nb_init  = p_reg[PSH+QW-1:PSH];
                    div_ctrl.iters    = CW'(QW);
                end
            end
            default:
            begin
                div_ctrl = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (in_fire) state_next = S_SQR;
            S_SQR:     state_next = S_ADD;
            S_ADD:     state_next = S_PEN_GO;
            S_PEN_GO:  state_next = (s_reg == '0) ? S_FIN : S_PEN_RUN;
            S_PEN_RUN: if (!div_stat.busy) state_next = term_on_reg ? S_R_RUN : S_FIN;
            S_R_RUN:   if (!div_stat.busy) state_next = S_QCHK;
            S_QCHK:    state_next = p_ovf ? S_FIN : S_Q_RUN;
            S_Q_RUN:   if (!div_stat.busy) state_next = S_FIN;
            S_FIN:     if (fin_go) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enable_reg    <= 1'b0;
            alpha_reg     <= '0;
            w0_reg        <= '0;
            fan_in_reg    <= FAN_W'(1);
            pos_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLE:   enable_reg <= cfg_data[0];
                    CFG_ALPHA:    alpha_reg  <= cfg_data[ALPHA_W-1:0];
                    CFG_SCALE_W0: w0_reg     <= cfg_data[W0_W-1:0];
                    CFG_FAN_IN:   fan_in_reg <= cfg_data[FAN_W-1:0];
                    default:      enable_reg <= enable_reg;
                endcase
            end
            if (in_fire)
            begin
                pos_reg <= (sample.last_weight || bias_now) ? '0 : pos_reg + FAN_W'(1);
            end
            if (fin_go)
            begin
                acc_reg <= last_reg ? '0 : acc_next;
            end
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            wmag_reg    <= w_abs;
            neg_reg     <= w_in[DATA_W-1];
            grad_reg    <= sample.gradient_in;
            last_reg    <= sample.last_weight;
            bias_reg    <= bias_now;
            term_on_reg <= enable_reg && !bias_now;
            pen_reg     <= '0;
            mag_reg     <= '0;
        end
        if (state_reg == S_SQR)
        begin
            w2_reg <= w2_full;
            v2_reg <= v2_full;
            m_reg  <= m_full;
        end
        if (state_reg == S_ADD)
        begin
            s_reg <= w2_reg + 63'(v2_reg);
        end
        if (state_reg == S_PEN_RUN && !div_stat.busy)
        begin
            pen_reg <= div_stat.quot[FRAC_BITS:0];
            p_reg   <= '0;
        end
        // fold in the ratio bits as they leave the divider
        if (state_reg == S_R_RUN)
        begin
            p_reg <= p_next;
        end
        if (state_reg == S_QCHK && p_ovf)
        begin
            mag_reg <= TERM_CAP;
        end
        if (state_reg == S_Q_RUN && !div_stat.busy)
        begin
            mag_reg <= (div_stat.quot > TERM_CAP) ? TERM_CAP : div_stat.quot;
        end
        if (fin_go)
        begin
            grad_out_reg <= gsat;
            is_bias_reg  <= bias_reg;
            sum_out_reg  <= acc_next;
            last_out_reg <= last_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.gradient_out = grad_out_reg;
    assign result.is_bias      = is_bias_reg;
    assign result.penalty_sum  = sum_out_reg;
    assign result.last_out     = last_out_reg;

`ifndef SYNTHESIS
    a_div_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == S_PEN_RUN || state_reg == S_R_RUN
                           || state_reg == S_Q_RUN))
        else $error("divider running outside a divide state");

    a_bias_no_term: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && bias_reg) |-> mag_reg == '0)
        else $error("gradient term on a bias entry");

    a_pen_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> pen_reg <= (FRAC_BITS+1)'(1) << FRAC_BITS)
        else $error("penalty above one");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && last_reg) |=> (acc_reg == '0 && pos_reg == '0))
        else $error("sum or position not cleared after last beat");
`endif

endmodule

`default_nettype wire
